// File: src/stq_pkg.sv
// shared constants, codes and the entry type of the sorted timer queue
`timescale 1ns / 1ps
package stq_pkg;

	localparam int QUEUE_DEPTH = 16;
	localparam int ID_BITS     = 8;

	localparam int ADDR_W   = $clog2(QUEUE_DEPTH);
	localparam int CNT_W    = $clog2(QUEUE_DEPTH + 1);
	localparam int REQ_W    = 2;
	localparam int TID_W    = 8;
	localparam int TIME_W   = 64;
	localparam int STATUS_W = 2;

	localparam logic [REQ_W-1:0] REQ_ADD  = 2'd0;
	localparam logic [REQ_W-1:0] REQ_DEL  = 2'd1;
	localparam logic [REQ_W-1:0] REQ_TICK = 2'd2;

	localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
	localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;
	localparam logic [STATUS_W-1:0] ST_DUPLICATE = 2'd3;

	typedef struct packed {
		logic [ID_BITS-1:0] handle;
		logic [TIME_W-1:0]  expiry;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

endpackage

// File: src/stq_if.sv
// request and result channel interfaces of the sorted timer queue
`timescale 1ns / 1ps
interface stq_req_if import stq_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [REQ_W-1:0]  req_type;
	logic [TID_W-1:0]  timer_id;
	logic [TIME_W-1:0] expire_time;
	logic [TIME_W-1:0] current_time;

	modport source (output valid, req_type, timer_id, expire_time, current_time, input ready);
	modport sink (input valid, req_type, timer_id, expire_time, current_time, output ready);
endinterface

interface stq_rsp_if import stq_pkg::*; ();
	logic                valid;
	logic                ready;
	logic                fired;
	logic [TID_W-1:0]    fired_id;
	logic [STATUS_W-1:0] status;
	logic                last;

	modport source (output valid, fired, fired_id, status, last, input ready);
	modport sink (input valid, fired, fired_id, status, last, output ready);
endinterface

// File: src/stq_ram.sv
// generic simple dual-port ram with registered read
`timescale 1ns / 1ps
module stq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// File: src/sorted_timer_queue.sv
// sorted timer queue: top level with the ram walker and result register
// Holds up to QUEUE_DEPTH timers in one ram kept in ascending expiry order, head at entry 0.
// Add, delete and tick requests are taken one at a time; each is handled by walks over the ram
// through its single read port, one entry per cycle while the result side does not hold the
// read-out: a scan (add and delete look at every queued entry, a tick stops at the first entry
// not yet due), for a tick a read-out of the due entries, then a shift that closes or opens a gap.
// Every request gives at least one result; a tick gives one result per fired timer and marks the
// final one with last. No clearing pass is needed after reset.
`timescale 1ns / 1ps
module sorted_timer_queue import stq_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	stq_req_if.sink   request,
	stq_rsp_if.source result
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_SCAN = 3'd1;
	localparam logic [2:0] S_EMIT = 3'd2;
	localparam logic [2:0] S_MOVE = 3'd3;
	localparam logic [2:0] S_RESP = 3'd4;

	logic [2:0]          state_q;
	logic [REQ_W-1:0]    req_q;
	logic [ID_BITS-1:0]  id_q;
	logic [TIME_W-1:0]   exp_q;
	logic [TIME_W-1:0]   now_q;
	logic [CNT_W-1:0]    count_q;
	logic [CNT_W-1:0]    idx_q;
	logic [CNT_W-1:0]    rem_q;
	logic [CNT_W-1:0]    pos_q;
	logic [CNT_W-1:0]    nfire_q;
	logic [CNT_W-1:0]    dist_q;
	logic                down_q;
	logic                found_q;
	logic                dup_q;
	logic [STATUS_W-1:0] resp_status_q;
	logic                vld_s1;
	logic [ADDR_W-1:0]   addr_s1;

	logic                out_valid_q;
	logic                out_fired_q;
	logic [TID_W-1:0]    out_id_q;
	logic [STATUS_W-1:0] out_status_q;
	logic                out_last_q;

	entry_t            rd_entry;
	entry_t            ram_wdata;
	logic [ENTRY_W-1:0] ram_rdata;
	logic              ram_we;
	logic [ADDR_W-1:0] ram_waddr;
	logic [ADDR_W-1:0] ram_raddr;

	logic              accept;
	logic              out_free;
	logic              stall;
	logic              walk_done;
	logic              hit_id;
	logic              exp_ge;
	logic              due;
	logic              tick_stop;
	logic [CNT_W-1:0]  pos_eff;
	logic              out_load;
	logic              out_fired_d;
	logic [TID_W-1:0]  out_id_d;
	logic [STATUS_W-1:0] out_status_d;
	logic              out_last_d;

	stq_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(QUEUE_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign rd_entry      = entry_t'(ram_rdata);
	assign request.ready = (state_q == S_IDLE);
	assign accept        = request.valid && request.ready;
	assign out_free      = !out_valid_q || result.ready;
	assign stall         = (state_q == S_EMIT) && vld_s1 && !out_free;
	assign ram_raddr     = stall ? addr_s1 : idx_q[ADDR_W-1:0];
	assign walk_done     = (rem_q == '0) && !vld_s1;
	assign hit_id        = (rd_entry.handle == id_q);
	assign exp_ge        = (rd_entry.expiry >= exp_q);
	assign due           = (rd_entry.expiry <= now_q);
	assign tick_stop     = vld_s1 && (req_q == REQ_TICK) && !due;
	assign pos_eff       = found_q ? pos_q : count_q;

	// ram write: shift step or insertion of the new entry
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = addr_s1;
		ram_wdata = rd_entry;
		if (state_q == S_MOVE) begin
			if (vld_s1) begin
				ram_we    = 1'b1;
				ram_waddr = down_q ? addr_s1 + ADDR_W'(1) : addr_s1 - dist_q[ADDR_W-1:0];
			end else if (rem_q == '0 && req_q == REQ_ADD) begin
				ram_we           = 1'b1;
				ram_waddr        = pos_q[ADDR_W-1:0];
				ram_wdata.handle = id_q;
				ram_wdata.expiry = exp_q;
			end
		end
	end

	// result register load
	always_comb begin
		out_load     = 1'b0;
		out_fired_d  = 1'b0;
		out_id_d     = '0;
		out_status_d = resp_status_q;
		out_last_d   = 1'b1;
		if (state_q == S_EMIT && vld_s1 && out_free) begin
			out_load     = 1'b1;
			out_fired_d  = 1'b1;
			out_id_d     = TID_W'(rd_entry.handle);
			out_status_d = ST_OK;
			out_last_d   = (addr_s1 == ADDR_W'(nfire_q - CNT_W'(1)));
		end else if (state_q == S_RESP && out_free) begin
			out_load = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= request.req_type;
			id_q  <= ID_BITS'(request.timer_id);
			exp_q <= request.expire_time;
			now_q <= request.current_time;
		end
		if (out_load) begin
			out_fired_q  <= out_fired_d;
			out_id_q     <= out_id_d;
			out_status_q <= out_status_d;
			out_last_q   <= out_last_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			count_q       <= '0;
			idx_q         <= '0;
			rem_q         <= '0;
			pos_q         <= '0;
			nfire_q       <= '0;
			dist_q        <= '0;
			down_q        <= 1'b0;
			found_q       <= 1'b0;
			dup_q         <= 1'b0;
			resp_status_q <= ST_OK;
			vld_s1        <= 1'b0;
			addr_s1       <= '0;
		end else begin
			// shared walk: issue one read per cycle while entries remain and no stall holds the read-out
			if (state_q != S_IDLE && state_q != S_RESP && !stall) begin
				if (rem_q != '0) begin
					idx_q   <= down_q ? idx_q - CNT_W'(1) : idx_q + CNT_W'(1);
					rem_q   <= rem_q - CNT_W'(1);
					addr_s1 <= idx_q[ADDR_W-1:0];
					vld_s1  <= 1'b1;
				end else begin
					vld_s1 <= 1'b0;
				end
			end

			case (state_q)
				S_IDLE: begin
					if (accept) begin
						idx_q   <= '0;
						down_q  <= 1'b0;
						found_q <= 1'b0;
						dup_q   <= 1'b0;
						nfire_q <= '0;
						vld_s1  <= 1'b0;
						if (request.req_type inside {REQ_ADD, REQ_DEL, REQ_TICK}) begin
							rem_q   <= count_q;
							state_q <= S_SCAN;
						end else begin
							rem_q         <= '0;
							resp_status_q <= ST_OK;
							state_q       <= S_RESP;
						end
					end
				end
				S_SCAN: begin
					if (vld_s1) begin
						case (req_q)
							REQ_ADD: begin
								if (hit_id) begin
									dup_q <= 1'b1;
								end
								if (exp_ge && !found_q) begin
									found_q <= 1'b1;
									pos_q   <= CNT_W'(addr_s1);
								end
							end
							REQ_DEL: begin
								if (hit_id && !found_q) begin
									found_q <= 1'b1;
									pos_q   <= CNT_W'(addr_s1);
								end
							end
							REQ_TICK: begin
								if (due) begin
									nfire_q <= nfire_q + CNT_W'(1);
								end
							end
							default: begin
							end
						endcase
					end
					if (walk_done || tick_stop) begin
						vld_s1 <= 1'b0;
						case (req_q)
							REQ_ADD: begin
								if (dup_q) begin
									resp_status_q <= ST_DUPLICATE;
									rem_q         <= '0;
									state_q       <= S_RESP;
								end else if (count_q == CNT_W'(QUEUE_DEPTH)) begin
									resp_status_q <= ST_FULL;
									rem_q         <= '0;
									state_q       <= S_RESP;
								end else begin
									pos_q   <= pos_eff;
									idx_q   <= count_q - CNT_W'(1);
									rem_q   <= count_q - pos_eff;
									down_q  <= 1'b1;
									state_q <= S_MOVE;
								end
							end
							REQ_DEL: begin
								if (!found_q) begin
									resp_status_q <= ST_NOT_FOUND;
									rem_q         <= '0;
									state_q       <= S_RESP;
								end else begin
									idx_q   <= pos_q + CNT_W'(1);
									rem_q   <= count_q - pos_q - CNT_W'(1);
									dist_q  <= CNT_W'(1);
									down_q  <= 1'b0;
									state_q <= S_MOVE;
								end
							end
							default: begin
								if (nfire_q == '0) begin
									resp_status_q <= ST_OK;
									rem_q         <= '0;
									state_q       <= S_RESP;
								end else begin
									idx_q   <= '0;
									rem_q   <= nfire_q;
									down_q  <= 1'b0;
									state_q <= S_EMIT;
								end
							end
						endcase
					end
				end
				S_EMIT: begin
					if (walk_done) begin
						idx_q   <= nfire_q;
						rem_q   <= count_q - nfire_q;
						dist_q  <= nfire_q;
						down_q  <= 1'b0;
						state_q <= S_MOVE;
					end
				end
				S_MOVE: begin
					if (walk_done) begin
						case (req_q)
							REQ_ADD: begin
								count_q       <= count_q + CNT_W'(1);
								resp_status_q <= ST_OK;
								state_q       <= S_RESP;
							end
							REQ_DEL: begin
								count_q       <= count_q - CNT_W'(1);
								resp_status_q <= ST_OK;
								state_q       <= S_RESP;
							end
							default: begin
								count_q <= count_q - nfire_q;
								state_q <= S_IDLE;
							end
						endcase
					end
				end
				S_RESP: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(QUEUE_DEPTH))
		else $error("entry count above queue depth");

	a_count_idle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE |=> $stable(count_q))
		else $error("entry count changed outside a request");

	a_fired_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_fired_q |-> out_last_q)
		else $error("result without a fired timer is not last");

	a_emit_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_EMIT |-> !ram_we)
		else $error("ram written while reading out due timers");

	assign result.valid    = out_valid_q;
	assign result.fired    = out_fired_q;
	assign result.fired_id = out_id_q;
	assign result.status   = out_status_q;
	assign result.last     = out_last_q;

endmodule

// File: bench/stq_checker.sv
// predictor and result checker for the sorted timer queue bench
`timescale 1ns / 1ps
module stq_checker import stq_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	stq_req_if   request,
	stq_rsp_if   result,
	output int   fail_count,
	output int   pending_results
);

	typedef struct packed {
		logic                fired;
		logic [TID_W-1:0]    fired_id;
		logic [STATUS_W-1:0] status;
		logic                last;
	} outcome_t;

	outcome_t due_results[$];
	entry_t   timers[QUEUE_DEPTH];
	int       n_timers;
	int       n_fail;

	function automatic outcome_t make_outcome(logic fired, logic [TID_W-1:0] id,
			logic [STATUS_W-1:0] status, logic last);
		outcome_t o;
		o.fired    = fired;
		o.fired_id = id;
		o.status   = status;
		o.last     = last;
		return o;
	endfunction

	function automatic int find_timer(logic [ID_BITS-1:0] id);
		for (int i = 0; i < n_timers; i++) begin
			if (timers[i].handle == id)
				return i;
		end
		return -1;
	endfunction

	task automatic drop_timer(int pos);
		for (int i = pos; i + 1 < n_timers; i++)
			timers[i] = timers[i + 1];
		n_timers--;
	endtask

	task automatic predict_request(logic [REQ_W-1:0] kind, logic [TID_W-1:0] tid,
			logic [TIME_W-1:0] expiry, logic [TIME_W-1:0] now);
		logic [ID_BITS-1:0] id;
		int pos;
		int n_fired;
		id = tid[ID_BITS-1:0];
		n_fired = 0;
		case (kind)
			REQ_ADD: begin
				if (find_timer(id) >= 0) begin
					due_results.push_back(make_outcome(1'b0, '0, ST_DUPLICATE, 1'b1));
				end else if (n_timers >= QUEUE_DEPTH) begin
					due_results.push_back(make_outcome(1'b0, '0, ST_FULL, 1'b1));
				end else begin
					pos = 0;
					while (pos < n_timers && timers[pos].expiry < expiry)
						pos++;
					for (int i = n_timers; i > pos; i--)
						timers[i] = timers[i - 1];
					timers[pos].handle = id;
					timers[pos].expiry = expiry;
					n_timers++;
					due_results.push_back(make_outcome(1'b0, '0, ST_OK, 1'b1));
				end
			end
			REQ_DEL: begin
				pos = find_timer(id);
				if (pos < 0) begin
					due_results.push_back(make_outcome(1'b0, '0, ST_NOT_FOUND, 1'b1));
				end else begin
					drop_timer(pos);
					due_results.push_back(make_outcome(1'b0, '0, ST_OK, 1'b1));
				end
			end
			REQ_TICK: begin
				while (n_timers > 0 && timers[0].expiry <= now) begin
					due_results.push_back(make_outcome(1'b1, TID_W'(timers[0].handle), ST_OK, 1'b0));
					drop_timer(0);
					n_fired++;
				end
				if (n_fired == 0)
					due_results.push_back(make_outcome(1'b0, '0, ST_OK, 1'b1));
				else
					due_results[due_results.size() - 1].last = 1'b1;
			end
			default: begin
				due_results.push_back(make_outcome(1'b0, '0, ST_OK, 1'b1));
			end
		endcase
	endtask

	task automatic compare_field(string field, logic [TID_W-1:0] want, logic [TID_W-1:0] got);
		if (got !== want) begin
			$error("%s expected %0h actual %0h", field, want, got);
			n_fail++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		outcome_t want;
		if (!arst_n) begin
			n_timers = 0;
			due_results.delete();
			pending_results <= 0;
			fail_count <= n_fail;
		end else begin
			if (request.valid && request.ready)
				predict_request(request.req_type, request.timer_id, request.expire_time,
					request.current_time);
			if (result.valid && result.ready) begin
				if (due_results.size() == 0) begin
					$error("result item with no expectation waiting");
					n_fail++;
				end else begin
					want = due_results.pop_front();
					compare_field("fired", TID_W'(want.fired), TID_W'(result.fired));
					compare_field("fired_id", want.fired_id, result.fired_id);
					compare_field("status", TID_W'(want.status), TID_W'(result.status));
					compare_field("last", TID_W'(want.last), TID_W'(result.last));
				end
			end
			pending_results <= due_results.size();
			fail_count <= n_fail;
		end
	end

endmodule

// File: bench/sorted_timer_queue_tb.sv
// top of the sorted timer queue bench: clock, reset, stimulus and verdict
`timescale 1ns / 1ps
module sorted_timer_queue_tb import stq_pkg::*; ();

	localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
	localparam int RANDOM_ITEMS   = 110;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int SETTLE_CYCLES  = 60;
	localparam int POOL_SIZE      = 8;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int   fail_count;
	int   pending_results;
	int   idle_cycles = 0;
	int   items_sent = 0;
	int   send_calm = 0;
	int   take_calm = 0;

	logic [TIME_W-1:0] tick_now;
	logic [TID_W-1:0]  handle_pool[POOL_SIZE];

	always #2 clk = ~clk;

	stq_req_if request();
	stq_rsp_if result();

	sorted_timer_queue dut (
		.clk    (clk),
		.arst_n (arst_n),
		.request(request),
		.result (result)
	);

	stq_checker timer_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.request        (request),
		.result         (result),
		.fail_count     (fail_count),
		.pending_results(pending_results)
	);

	function automatic logic [TIME_W-1:0] rand_time();
		return {$urandom(), $urandom()};
	endfunction

	function automatic int pick_pause(inout int calm);
		int r;
		if (calm > 0) begin
			calm--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 8)
			calm = $urandom_range(10, 30);
		if (r < 60)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	task automatic send_request(logic [REQ_W-1:0] kind, logic [TID_W-1:0] id,
			logic [TIME_W-1:0] expiry, logic [TIME_W-1:0] now);
		int gap;
		request.valid        <= 1'b1;
		request.req_type     <= kind;
		request.timer_id     <= id;
		request.expire_time  <= expiry;
		request.current_time <= now;
		@(posedge clk);
		while (!request.ready)
			@(posedge clk);
		items_sent++;
		gap = pick_pause(send_calm);
		if (gap > 0) begin
			request.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic wait_all_results();
		request.valid <= 1'b0;
		@(posedge clk);
		while (pending_results != 0)
			@(posedge clk);
	endtask

	task automatic mixed_sequence();
		int len;
		int r;
		len = $urandom_range(4, 10);
		handle_pool[$urandom_range(0, POOL_SIZE - 1)] = TID_W'($urandom());
		for (int k = 0; k < len; k++) begin
			r = $urandom_range(0, 99);
			if (r < 45) begin
				send_request(REQ_ADD, handle_pool[$urandom_range(0, POOL_SIZE - 1)],
					tick_now + $urandom_range(0, 24), rand_time());
			end else if (r < 65) begin
				send_request(REQ_DEL, handle_pool[$urandom_range(0, POOL_SIZE - 1)],
					rand_time(), rand_time());
			end else begin
				tick_now = tick_now + $urandom_range(0, 10);
				send_request(REQ_TICK, TID_W'($urandom()), rand_time(), tick_now);
			end
		end
	endtask

	task automatic fill_and_flush();
		logic [TID_W-1:0] base;
		base = TID_W'($urandom());
		for (int k = 0; k < QUEUE_DEPTH + 2; k++)
			send_request(REQ_ADD, base + TID_W'(k * 7), ($urandom_range(0, 3) == 0) ?
				'1 : tick_now + $urandom_range(0, 40), rand_time());
		send_request(REQ_ADD, base, rand_time(), rand_time());
		send_request(REQ_TICK, TID_W'($urandom()), rand_time(), '1);
	endtask

	initial begin
		forever begin
			@(posedge clk);
			result.ready <= 1'b1;
			repeat ($urandom_range(0, 6)) @(posedge clk);
			if (pick_pause(take_calm) > 0) begin
				result.ready <= 1'b0;
				repeat (pick_pause(take_calm) + 1) @(posedge clk);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (request.valid && request.ready) || (result.valid && result.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("sorted_timer_queue regression: fail");
			$finish;
		end
	end

	initial begin
		int target;
		int r;
		request.valid        = 1'b0;
		request.req_type     = REQ_ADD;
		request.timer_id     = '0;
		request.expire_time  = '0;
		request.current_time = '0;
		result.ready         = 1'b0;
		foreach (handle_pool[i])
			handle_pool[i] = TID_W'($urandom());
		tick_now = rand_time();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// empty queue, extremes of handle and expiry, equal expiries, duplicate
		send_request(REQ_TICK, 8'h00, '0, '0);
		send_request(REQ_DEL, 8'h00, '0, '0);
		send_request(REQ_ADD, 8'h00, '0, '1);
		send_request(REQ_ADD, 8'hff, '1, '0);
		send_request(REQ_ADD, 8'h5a, 64'd100, '0);
		send_request(REQ_ADD, 8'ha5, 64'd100, '1);
		send_request(REQ_ADD, 8'h00, 64'd7, '0);
		send_request(REQ_TICK, 8'hff, '1, 64'd99);
		send_request(REQ_TICK, 8'h00, '0, 64'd100);
		send_request(REQ_DEL, 8'hff, '0, '1);
		send_request(REQ_DEL, 8'hff, '1, '0);
		send_request(REQ_TICK, 8'h00, '0, '1);
		send_request(REQ_UNUSED, 8'hff, '1, '1);
		send_request(REQ_UNUSED, 8'h00, '0, '0);
		wait_all_results();

		fill_and_flush();
		target = RANDOM_ITEMS;
		while (items_sent < target) begin
			r = $urandom_range(0, 99);
			if (r < 60) begin
				mixed_sequence();
			end else if (r < 64) begin
				fill_and_flush();
			end else if (r < 72) begin
				wait_all_results();
			end else if (r < 88) begin
				send_request(REQ_TICK + REQ_W'($urandom_range(0, 3)), TID_W'($urandom()),
					rand_time(), rand_time());
			end else begin
				tick_now = rand_time();
				send_request(REQ_TICK, TID_W'($urandom()), rand_time(), tick_now);
			end
		end

		wait_all_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("sorted_timer_queue regression: pass");
		else
			$display("sorted_timer_queue regression: fail");
		$finish;
	end

endmodule
